// ===== rtl/core/lir_pkg.sv =====
// ----------------------------------------------------------------------------
// lir_pkg
// Shared types and constants of the linear interpolation resampler: rate
// register format, register indexes, reset rates and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package lir_pkg;

    // rate registers
    localparam int RATE_BITS = 18;
    typedef logic [RATE_BITS-1:0] t_rate;

    localparam t_rate SOURCE_RATE_RESET = 18'd48000;
    localparam t_rate TARGET_RATE_RESET = 18'd16000;

    // register indexes of the config port
    localparam int REG_INDEX_BITS = 1;
    localparam logic [REG_INDEX_BITS-1:0] REG_SOURCE_RATE = 1'b0;
    localparam logic [REG_INDEX_BITS-1:0] REG_TARGET_RATE = 1'b1;

    // rates captured with each item, already sanitized
    typedef struct packed {
        t_rate src;
        t_rate dst;
    } t_rates;

    // depth of the item queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // non-negative position differences at or beyond 2^SPAN_BITS always allow an output
    localparam int SPAN_BITS = 22;

    // back-end sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM_GO,
        ST_NORM_WAIT,
        ST_CHECK,
        ST_IMUL,
        ST_ISTART,
        ST_IDIV,
        ST_EMUL,
        ST_ECMP,
        ST_ADV,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/lir_front.sv =====
// ----------------------------------------------------------------------------
// lir_front
// Front end: rate registers, rate sanitizing and input item capture into
// the item queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lir_front #(
    parameter int SAMPLE_BITS  = 16,
    parameter int MAX_UPSAMPLE = 8
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [lir_pkg::REG_INDEX_BITS-1:0]    i_cfg_index,
    input  wire logic [lir_pkg::RATE_BITS-1:0]         i_cfg_data,
    input  wire logic                                  i_valid,
    input  wire logic signed [SAMPLE_BITS-1:0]         i_in_sample,
    input  wire logic                                  i_final_sample,
    input  wire logic                                  i_q_full,
    output logic                                       o_ready,
    output logic                                       o_push,
    output logic [SAMPLE_BITS+2*lir_pkg::RATE_BITS:0]  o_entry
);
    import lir_pkg::*;

    localparam int RB = RATE_BITS;
    localparam int LB = RB + $clog2(MAX_UPSAMPLE + 1);

    t_rate r_src;
    t_rate r_dst;

    t_rate          w_src;
    t_rate          w_dst0;
    t_rate          w_dst;
    logic [LB-1:0]  w_lim;
    t_rates         w_rates;

    // rate registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src <= SOURCE_RATE_RESET;
            r_dst <= TARGET_RATE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SOURCE_RATE: r_src <= i_cfg_data;
                REG_TARGET_RATE: r_dst <= i_cfg_data;
            endcase
        end
    end

    // zero acts as one; target saturates at MAX_UPSAMPLE times source
    assign w_src  = (r_src == '0) ? RB'(1) : r_src;
    assign w_dst0 = (r_dst == '0) ? RB'(1) : r_dst;
    assign w_lim  = LB'(w_src) * LB'(MAX_UPSAMPLE);
    assign w_dst  = (LB'(w_dst0) > w_lim) ? RB'(w_lim) : w_dst0;

    assign w_rates.src = w_src;
    assign w_rates.dst = w_dst;

    // item capture
    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;
    assign o_entry = {i_in_sample, i_final_sample, w_rates};

endmodule

`default_nettype wire

// ===== rtl/core/lir_queue.sv =====
// ----------------------------------------------------------------------------
// lir_queue
// Small FIFO that decouples item capture from the interpolation back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lir_queue #(
    parameter int WIDTH = 53
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);
    import lir_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;

    logic w_do_push;
    logic w_do_pop;

    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                     : r_wr_ptr + PTR_BITS'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                     : r_rd_ptr + PTR_BITS'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CNT_BITS'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - CNT_BITS'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_full  = (r_count == CNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

// ===== rtl/core/lir_div.sv =====
// ----------------------------------------------------------------------------
// lir_div
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits in QUO_BITS.
// ----------------------------------------------------------------------------
`default_nettype none

module lir_div #(
    parameter int NUM_BITS = 37,
    parameter int DEN_BITS = 19,
    parameter int QUO_BITS = 18
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [NUM_BITS-1:0] i_num,
    input  wire logic [DEN_BITS-1:0] i_den,
    output logic                     o_busy,
    output logic [QUO_BITS-1:0]      o_quo,
    output logic [DEN_BITS-1:0]      o_rem
);
    localparam int CB = $clog2(QUO_BITS + 1);

    logic                r_busy;
    logic [CB-1:0]       r_cnt;
    logic [DEN_BITS-1:0] r_den;
    logic [DEN_BITS:0]   r_part;
    logic [QUO_BITS-1:0] r_acc;

    logic [DEN_BITS:0]   w_trial;
    logic [DEN_BITS:0]   w_sub;
    logic                w_ge;

    // one trial subtraction per cycle
    assign w_trial = {r_part[DEN_BITS-1:0], r_acc[QUO_BITS-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_sub   = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CB'(1);
            if (r_cnt == CB'(QUO_BITS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den  <= i_den;
            r_part <= (DEN_BITS+1)'(i_num >> QUO_BITS);
            r_acc  <= i_num[QUO_BITS-1:0];
        end else if (r_busy) begin
            r_part <= w_ge ? w_sub : w_trial;
            r_acc  <= {r_acc[QUO_BITS-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_acc;
    assign o_rem  = r_part[DEN_BITS-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/lir_back.sv =====
// ----------------------------------------------------------------------------
// lir_back
// Back end: per-item sequencer that tracks the next output position, forms
// interpolated values through the shared divider, and delivers results with
// run_end marked on the last one of each item.
// ----------------------------------------------------------------------------
`default_nettype none

module lir_back #(
    parameter int SAMPLE_BITS  = 16,
    parameter int MAX_UPSAMPLE = 8,
    parameter int COUNT_BITS   = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_valid,
    input  wire logic [SAMPLE_BITS-1:0]        i_q_sample,
    input  wire logic                          i_q_final,
    input  wire lir_pkg::t_rates               i_q_rates,
    output logic                               o_q_pop,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0]      o_out_sample,
    output logic                               o_run_end,
    output logic                               o_stream_end
);
    import lir_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int CB  = COUNT_BITS;
    localparam int RB  = RATE_BITS;
    localparam int DB  = RB + 1;
    localparam int QB  = (SB + 2 > RB) ? SB + 2 : RB;
    localparam int NB  = SB + RB + 3;
    localparam int PB  = SB + RB + 2;
    localparam int XB  = SPAN_BITS + RB;
    localparam int MR  = 2 * MAX_UPSAMPLE;
    localparam int MRB = $clog2(MR + 1);

    t_state r_state;
    t_state n_state;

    // current item
    logic [SB-1:0] r_x;
    logic          r_fin;
    t_rate         r_src;
    t_rate         r_dst;

    // stream state
    logic [SB-1:0] r_prev;
    logic [CB-1:0] r_m;
    logic [CB-1:0] r_base;
    t_rate         r_rem;
    logic          r_held_valid;
    logic [SB-1:0] r_held;
    logic [MRB-1:0] r_count;

    // arithmetic stage registers
    logic signed [PB-1:0] r_prod;
    logic [XB-1:0]        r_dprod;
    logic                 r_dneg;
    logic                 r_dbig;

    // pending result (run_end not yet known) and output register
    logic          r_pend_valid;
    logic [SB-1:0] r_pend_sample;
    logic          r_pend_stream;
    logic          r_out_valid;
    logic [SB-1:0] r_out_sample;
    logic          r_out_run_end;
    logic          r_out_stream_end;

    // divider
    logic          w_div_start;
    logic [NB-1:0] w_div_num;
    logic [DB-1:0] w_div_den;
    logic          w_div_busy;
    logic [QB-1:0] w_div_quo;
    logic [DB-1:0] w_div_rem;

    logic [CB-1:0]        w_d0;
    logic                 w_d0_zero;
    logic [CB-1:0]        w_c;
    logic [CB-1:0]        w_d;
    logic [SPAN_BITS-1:0] w_dsmall;
    logic [RB:0]          w_step_sum;
    logic                 w_may;
    logic signed [SB:0]   w_diff;
    logic signed [NB-1:0] w_prod_ext;
    logic [NB-1:0]        w_interp_num;
    logic [SB-1:0]        w_interp_res;
    logic                 w_out_free;
    logic                 w_push_ok;
    logic                 w_stop;
    logic                 w_emit;
    logic                 w_flush;
    logic                 w_push_out;

    lir_div #(
        .NUM_BITS (NB),
        .DEN_BITS (DB),
        .QUO_BITS (QB)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_busy  (w_div_busy),
        .o_quo   (w_div_quo),
        .o_rem   (w_div_rem)
    );

    // position bookkeeping
    assign w_d0      = r_m - r_base;
    assign w_d0_zero = (w_d0 == '0);
    assign w_c       = r_m + CB'(1);
    assign w_d       = w_c - r_base;
    assign w_dsmall  = SPAN_BITS'(w_d);
    assign w_step_sum = {1'b0, r_rem} + {1'b0, r_src};
    assign w_may     = !r_dneg && (r_dbig || (XB'(w_step_sum) <= r_dprod));

    // interpolation: prev + floor((2*(x-prev)*r + dst) / (2*dst)), offset positive
    assign w_diff       = $signed({r_x[SB-1], r_x}) - $signed({r_prev[SB-1], r_prev});
    assign w_prod_ext   = NB'(r_prod);
    assign w_interp_num = {w_prod_ext[NB-2:0], 1'b0} + NB'(r_dst)
                          + (NB'(r_dst) << (SB + 1));
    assign w_interp_res = r_prev + SB'(w_div_quo);

    // handshake toward the output register
    assign w_out_free = !r_out_valid || i_ready;
    assign w_push_ok  = !r_pend_valid || w_out_free;

    assign w_stop = (r_count == MRB'(MR))
                 || (!r_held_valid && (w_d0[CB-1] || (w_d0_zero && !r_fin && (r_rem != '0))));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (i_q_valid) n_state = ST_NORM_GO;
            ST_NORM_GO:   n_state = ST_NORM_WAIT;
            ST_NORM_WAIT: if (!w_div_busy) n_state = ST_CHECK;
            ST_CHECK: begin
                if (w_stop) begin
                    n_state = ST_FINISH;
                end else if (r_held_valid || w_d0_zero) begin
                    n_state = ST_EMUL;
                end else begin
                    n_state = ST_IMUL;
                end
            end
            ST_IMUL:      n_state = ST_ISTART;
            ST_ISTART:    n_state = ST_IDIV;
            ST_IDIV:      if (!w_div_busy) n_state = ST_EMUL;
            ST_EMUL:      n_state = ST_ECMP;
            ST_ECMP: begin
                if (!w_may) begin
                    n_state = ST_FINISH;
                end else if (w_push_ok) begin
                    n_state = ST_ADV;
                end
            end
            ST_ADV:       if (!w_div_busy) n_state = ST_CHECK;
            ST_FINISH:    if (w_push_ok) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_q_pop     = 1'b0;
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_den   = '0;
        w_emit      = 1'b0;
        w_flush     = 1'b0;
        unique case (r_state)
            ST_IDLE: o_q_pop = i_q_valid;
            ST_NORM_GO: begin
                w_div_start = 1'b1;
                w_div_num   = NB'(r_rem);
                w_div_den   = DB'(r_dst);
            end
            ST_ISTART: begin
                w_div_start = 1'b1;
                w_div_num   = w_interp_num;
                w_div_den   = {r_dst, 1'b0};
            end
            ST_ECMP: begin
                if (w_may && w_push_ok) begin
                    w_emit      = 1'b1;
                    w_div_start = 1'b1;
                    w_div_num   = NB'(w_step_sum);
                    w_div_den   = DB'(r_dst);
                end
            end
            ST_FINISH: w_flush = w_push_ok;
            default: ;
        endcase
    end

    assign w_push_out = r_pend_valid && (w_emit || w_flush);

    // control and stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_prev       <= '0;
            r_m          <= '0;
            r_base       <= '0;
            r_rem        <= '0;
            r_held_valid <= 1'b0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: if (o_q_pop) r_count <= '0;
                ST_NORM_WAIT, ST_ADV: begin
                    if (!w_div_busy) begin
                        r_base <= r_base + CB'(w_div_quo);
                        r_rem  <= RB'(w_div_rem);
                    end
                end
                ST_CHECK: begin
                    if (!w_stop && !r_held_valid && w_d0_zero) begin
                        r_held_valid <= 1'b1;
                    end
                end
                ST_IDIV: if (!w_div_busy) r_held_valid <= 1'b1;
                ST_ECMP: begin
                    if (w_emit) begin
                        r_held_valid <= 1'b0;
                        r_count      <= r_count + MRB'(1);
                    end
                end
                ST_FINISH: begin
                    if (w_flush) begin
                        if (r_fin) begin
                            r_prev       <= '0;
                            r_m          <= '0;
                            r_base       <= '0;
                            r_rem        <= '0;
                            r_held_valid <= 1'b0;
                        end else begin
                            r_prev <= r_x;
                            r_m    <= w_c;
                        end
                    end
                end
                default: ;
            endcase

            if (w_emit) begin
                r_pend_valid <= 1'b1;
            end else if (w_flush) begin
                r_pend_valid <= 1'b0;
            end

            if (w_push_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_x   <= i_q_sample;
            r_fin <= i_q_final;
            r_src <= i_q_rates.src;
            r_dst <= i_q_rates.dst;
        end
        if (r_state == ST_CHECK && !r_held_valid) begin
            r_held <= r_x;
        end
        if (r_state == ST_IDIV && !w_div_busy) begin
            r_held <= w_interp_res;
        end
        if (r_state == ST_IMUL) begin
            r_prod <= w_diff * $signed({1'b0, r_rem});
        end
        if (r_state == ST_EMUL) begin
            r_dprod <= XB'(w_dsmall) * XB'(r_dst);
            r_dneg  <= w_d[CB-1];
            r_dbig  <= (64'(w_d) >= (64'd1 << SPAN_BITS));
        end
        if (w_emit) begin
            r_pend_sample <= r_held;
            r_pend_stream <= r_fin;
        end
        if (w_push_out) begin
            r_out_sample     <= r_pend_sample;
            r_out_run_end    <= w_flush;
            r_out_stream_end <= r_pend_stream;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_sample = r_out_sample;
    assign o_run_end    = r_out_run_end;
    assign o_stream_end = r_out_stream_end;

    // checks
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy)
        else $error("divider started while busy");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MRB'(MR))
        else $error("result count beyond limit");

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push_out |-> (!r_out_valid || i_ready))
        else $error("output register overwritten");

    a_stream_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && w_flush && r_fin)
        |=> (r_m == '0 && r_base == '0 && r_rem == '0 && !r_held_valid))
        else $error("stream state not cleared after final item");

    a_pend_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && w_flush) |=> (!r_pend_valid && r_state == ST_IDLE))
        else $error("pending result left at end of item");

endmodule

`default_nettype wire

// ===== rtl/core/linear_interp_resampler.sv =====
// ----------------------------------------------------------------------------
// linear_interp_resampler
// Streaming linear-interpolation sample rate converter for mono samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) takes one sample per item with
//   i_final_sample marking the last sample of a stream. Output channel
//   (o_valid/i_ready) delivers interpolated samples; o_run_end marks the
//   last result caused by an item, o_stream_end the results caused by the
//   final item. Rates are written through i_cfg_we/i_cfg_index/i_cfg_data
//   while the block is idle; zero acts as one, and target_rate saturates
//   at MAX_UPSAMPLE times source_rate.
//   Every interpolated value and every position step is formed by the
//   one-bit-per-cycle divider, whose quotient is Q = max(SAMPLE_BITS+2,
//   18) bits wide; results that land on an input sample need no
//   interpolating division. A two-entry queue takes items while the
//   back end works.
//   Each result moves to the output register when the item's next result
//   is formed, the last one when the item's work ends; a stall holds the
//   output register and then the back end. Reset restores 48000 / 16000
//   and clears the stream state; after a final item the stream state
//   returns to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_interp_resampler #(
    parameter int SAMPLE_BITS  = 16,
    parameter int MAX_UPSAMPLE = 8,
    parameter int COUNT_BITS   = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [lir_pkg::REG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [lir_pkg::RATE_BITS-1:0]      i_cfg_data,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]      i_in_sample,
    input  wire logic                               i_final_sample,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic signed [SAMPLE_BITS-1:0]           o_out_sample,
    output logic                                    o_run_end,
    output logic                                    o_stream_end
);
    import lir_pkg::*;

    localparam int RATES_BITS = 2 * RATE_BITS;
    localparam int ENTRY_BITS = SAMPLE_BITS + 1 + RATES_BITS;

    logic                  w_push;
    logic                  w_q_full;
    logic [ENTRY_BITS-1:0] w_entry;
    logic                  w_q_valid;
    logic                  w_q_pop;
    logic [ENTRY_BITS-1:0] w_q_data;
    t_rates                w_q_rates;

    lir_front #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .MAX_UPSAMPLE (MAX_UPSAMPLE)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .i_in_sample    (i_in_sample),
        .i_final_sample (i_final_sample),
        .i_q_full       (w_q_full),
        .o_ready        (o_ready),
        .o_push         (w_push),
        .o_entry        (w_entry)
    );

    lir_queue #(
        .WIDTH (ENTRY_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_entry),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    assign w_q_rates = w_q_data[RATES_BITS-1:0];

    lir_back #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .MAX_UPSAMPLE (MAX_UPSAMPLE),
        .COUNT_BITS   (COUNT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_q_sample   (w_q_data[ENTRY_BITS-1 -: SAMPLE_BITS]),
        .i_q_final    (w_q_data[RATES_BITS]),
        .i_q_rates    (w_q_rates),
        .o_q_pop      (w_q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_sample (o_out_sample),
        .o_run_end    (o_run_end),
        .o_stream_end (o_stream_end)
    );

endmodule

`default_nettype wire
